>>> hdl/icnp_pkg.sv
`timescale 1ns / 1ps

package icnp_pkg;

    // cache geometry
    localparam int NUM_WAYS    = 4;
    localparam int INDEX_BITS  = 6;
    localparam int OFFSET_BITS = 4;

    localparam int ADDR_BITS  = 32;
    localparam int TAG_BITS   = ADDR_BITS - INDEX_BITS - OFFSET_BITS;
    localparam int NUM_SETS   = 1 << INDEX_BITS;
    localparam int LINE_BYTES = 1 << OFFSET_BITS;
    localparam int WAY_BITS   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int LFSR_BITS  = 8;
    localparam int DELAY_BITS = 8;

    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [TAG_BITS-1:0]   tag_t;
    typedef logic [INDEX_BITS-1:0] set_t;
    typedef logic [WAY_BITS-1:0]   way_t;
    typedef logic [LFSR_BITS-1:0]  lfsr_t;
    typedef logic [DELAY_BITS-1:0] delay_t;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t REG_MEMORY_DELAY = 2'd0;
    localparam cfg_index_t REG_CACHE_DELAY  = 2'd1;
    localparam cfg_index_t REG_BOOT_ADDRESS = 2'd2;

    // register reset values
    localparam delay_t RST_MEMORY_DELAY = 8'd10;
    localparam delay_t RST_CACHE_DELAY  = 8'd1;
    localparam addr_t  RST_BOOT_ADDRESS = 32'h8000_0000;

    // one tag store write, also kept as the bypass record
    typedef struct packed {
        logic en;
        set_t set_idx;
        way_t way;
        tag_t tag;
    } tag_wr_t;

    // xnor lfsr step: shift left, insert not(b7 ^ b3 ^ b2 ^ b1)
    function automatic lfsr_t lfsr_next(input lfsr_t cur);
        logic fb;
        fb = ~(cur[7] ^ cur[3] ^ cur[2] ^ cur[1]);
        return {cur[LFSR_BITS-2:0], fb};
    endfunction

endpackage

>>> hdl/icache_hit_miss_next_line_prefetch_core.sv
`timescale 1ns / 1ps

// Instruction cache timing core: each fetch request (address plus cacheable flag) is
// looked up in a 4-way, 64-set tag store with 16-byte lines; a hit prefetches the next
// line into the cache, a miss fills the missed line, and the boot address always hits
// and fills its own line. Free ways fill lowest first, full sets pick a victim from an
// 8-bit xnor lfsr. One request is accepted every cycle unless a stalled result holds
// the input register; its result (miss flag and delay) then moves to the result
// register: the tag ram read register loads together with the input register, and
// the parallel way compare and fill finish before the result register. The result
// sits in an output register, so another request is taken in while it waits. Registers
// (0 memory delay, 1 cache delay, 2 boot address) are written with cfg_valid, which is
// always ready, and should only change while no request is in flight.
module icache_hit_miss_next_line_prefetch_core (
    input  logic                     clk,
    input  logic                     rst_n,
    // fetch requests
    input  logic                     in_valid,
    output logic                     in_stall,
    input  icnp_pkg::addr_t          fetch_address,
    input  logic                     cacheable,
    // results
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     miss,
    output icnp_pkg::delay_t         delay,
    // configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  icnp_pkg::cfg_index_t     cfg_index,
    input  logic [31:0]              cfg_data
);

    logic                    in_accept;
    logic                    s1_fire;

    logic                    s1_valid_reg;
    icnp_pkg::addr_t         s1_addr_reg;
    logic                    s1_cacheable_reg;

    logic                    out_valid_reg;
    logic                    miss_reg;
    icnp_pkg::delay_t        delay_reg;

    icnp_pkg::delay_t        memory_delay_reg;
    icnp_pkg::delay_t        cache_delay_reg;
    icnp_pkg::addr_t         boot_address_reg;

    icnp_pkg::lfsr_t         lfsr_reg;
    icnp_pkg::lfsr_t         lfsr_step;

    logic [icnp_pkg::NUM_WAYS-1:0] valid_reg [icnp_pkg::NUM_SETS];

    icnp_pkg::tag_wr_t       tag_wr;
    icnp_pkg::tag_wr_t       bypass_reg;

    icnp_pkg::set_t          rd_set_a;
    icnp_pkg::set_t          rd_set_b;
    icnp_pkg::tag_t          ram_a [icnp_pkg::NUM_WAYS];
    icnp_pkg::tag_t          ram_b [icnp_pkg::NUM_WAYS];

    icnp_pkg::set_t          set_a;
    icnp_pkg::set_t          set_b;
    icnp_pkg::addr_t         next_addr;
    icnp_pkg::tag_t          tag_a;
    icnp_pkg::tag_t          tag_b;
    logic [icnp_pkg::NUM_WAYS-1:0] valid_a;
    logic [icnp_pkg::NUM_WAYS-1:0] valid_b;
    logic [icnp_pkg::NUM_WAYS-1:0] hit_a;
    logic [icnp_pkg::NUM_WAYS-1:0] hit_b;
    logic                    is_boot;
    logic                    use_next;
    logic                    lookup_miss;
    icnp_pkg::set_t          ins_set;
    icnp_pkg::tag_t          ins_tag;
    logic [icnp_pkg::NUM_WAYS-1:0] ins_valid;
    logic                    ins_present;
    logic                    have_free;
    icnp_pkg::way_t          free_way;
    icnp_pkg::way_t          victim_way;
    logic                    take_victim;

    // handshakes
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign miss      = miss_reg;
    assign delay     = delay_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_delay_reg <= icnp_pkg::RST_MEMORY_DELAY;
            cache_delay_reg  <= icnp_pkg::RST_CACHE_DELAY;
            boot_address_reg <= icnp_pkg::RST_BOOT_ADDRESS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                icnp_pkg::REG_MEMORY_DELAY: memory_delay_reg <= cfg_data[icnp_pkg::DELAY_BITS-1:0];
                icnp_pkg::REG_CACHE_DELAY:  cache_delay_reg  <= cfg_data[icnp_pkg::DELAY_BITS-1:0];
                icnp_pkg::REG_BOOT_ADDRESS: boot_address_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // tag ram read addresses: the request's set and the following set
    assign rd_set_a = fetch_address[icnp_pkg::OFFSET_BITS +: icnp_pkg::INDEX_BITS];
    assign rd_set_b = rd_set_a + icnp_pkg::set_t'(1);

    // one tag ram per way
    for (genvar w = 0; w < icnp_pkg::NUM_WAYS; w++)
    begin : g_way
        icnp_tag_ram #(
            .ADDR_BITS (icnp_pkg::INDEX_BITS),
            .DATA_BITS (icnp_pkg::TAG_BITS)
        ) u_tag_ram (
            .clk       (clk),
            .wr_en     (tag_wr.en && (tag_wr.way == icnp_pkg::way_t'(w))),
            .wr_addr   (tag_wr.set_idx),
            .wr_data   (tag_wr.tag),
            .rd_en     (in_accept),
            .rd_addr_a (rd_set_a),
            .rd_addr_b (rd_set_b),
            .rd_data_a (ram_a[w]),
            .rd_data_b (ram_b[w])
        );
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg      <= fetch_address;
            s1_cacheable_reg <= cacheable;
        end
    end

    // address split for this line and the next one
    assign set_a     = s1_addr_reg[icnp_pkg::OFFSET_BITS +: icnp_pkg::INDEX_BITS];
    assign set_b     = set_a + icnp_pkg::set_t'(1);
    assign next_addr = s1_addr_reg + icnp_pkg::addr_t'(icnp_pkg::LINE_BYTES);
    assign tag_a     = s1_addr_reg[icnp_pkg::ADDR_BITS-1 -: icnp_pkg::TAG_BITS];
    assign tag_b     = next_addr[icnp_pkg::ADDR_BITS-1 -: icnp_pkg::TAG_BITS];
    assign valid_a   = valid_reg[set_a];
    assign valid_b   = valid_reg[set_b];

    // way compare, with the fill written on the read edge bypassed in
    always_comb
    begin
        icnp_pkg::tag_t way_tag_a;
        icnp_pkg::tag_t way_tag_b;
        for (int w = 0; w < icnp_pkg::NUM_WAYS; w++)
        begin
            way_tag_a = ram_a[w];
            way_tag_b = ram_b[w];
            if (bypass_reg.en && bypass_reg.way == icnp_pkg::way_t'(w))
            begin
                if (bypass_reg.set_idx == set_a)
                begin
                    way_tag_a = bypass_reg.tag;
                end
                if (bypass_reg.set_idx == set_b)
                begin
                    way_tag_b = bypass_reg.tag;
                end
            end
            hit_a[w] = valid_a[w] && (way_tag_a == tag_a);
            hit_b[w] = valid_b[w] && (way_tag_b == tag_b);
        end
    end

    // hit, miss and which line gets filled
    assign is_boot     = (s1_addr_reg == boot_address_reg);
    assign use_next    = !is_boot && (|hit_a);
    assign lookup_miss = !is_boot && !(|hit_a);
    assign ins_set     = use_next ? set_b : set_a;
    assign ins_tag     = use_next ? tag_b : tag_a;
    assign ins_valid   = use_next ? valid_b : valid_a;
    assign ins_present = use_next ? (|hit_b) : (|hit_a);

    // lowest free way
    always_comb
    begin
        free_way = '0;
        for (int w = icnp_pkg::NUM_WAYS - 1; w >= 0; w--)
        begin
            if (!ins_valid[w])
            begin
                free_way = icnp_pkg::way_t'(w);
            end
        end
    end

    assign have_free   = !(&ins_valid);
    assign lfsr_step   = icnp_pkg::lfsr_next(lfsr_reg);
    assign victim_way  = icnp_pkg::way_t'(lfsr_step
                                          & icnp_pkg::lfsr_t'(icnp_pkg::NUM_WAYS - 1));
    assign take_victim = s1_fire && !ins_present && !have_free;

    // fill request to the tag rams
    always_comb
    begin
        tag_wr.en      = s1_fire && !ins_present;
        tag_wr.set_idx = ins_set;
        tag_wr.way     = have_free ? free_way : victim_way;
        tag_wr.tag     = ins_tag;
    end

    // valid bits, lfsr and bypass record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < icnp_pkg::NUM_SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
            lfsr_reg   <= '0;
            bypass_reg <= '0;
        end
        else
        begin
            if (tag_wr.en)
            begin
                valid_reg[tag_wr.set_idx][tag_wr.way] <= 1'b1;
                bypass_reg <= tag_wr;
            end
            if (take_victim)
            begin
                lfsr_reg <= lfsr_step;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            miss_reg  <= lookup_miss;
            delay_reg <= (!s1_cacheable_reg || lookup_miss) ? memory_delay_reg
                                                            : cache_delay_reg;
        end
    end

endmodule

>>> hdl/icnp_tag_ram.sv
`timescale 1ns / 1ps

module icnp_tag_ram #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 22
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr_a,
    input  logic [ADDR_BITS-1:0] rd_addr_b,
    output logic [DATA_BITS-1:0] rd_data_a,
    output logic [DATA_BITS-1:0] rd_data_b
);

    logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];

    // one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // two registered read ports, old data on a same-edge write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
